// ----- sv/multilane_multiply_xorshift_hash_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multilane multiply-xorshift hash core
// Same-cycle-implication and next-cycle-implication checks on i_clk, disabled
// while i_rst_n is low. They compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MULTILANE_MULTIPLY_XORSHIFT_HASH_CORE_ASSERT_SVH
`define MULTILANE_MULTIPLY_XORSHIFT_HASH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MMXH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmxh assertion failed");
// next-cycle implication
`define MMXH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmxh assertion failed");
`else
`define MMXH_ASSERT_IMP(lbl, ante, cons)
`define MMXH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/mmxh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmxh_pkg
// Shared constants and controller-to-datapath command types for the hash core.
// ----------------------------------------------------------------------------
package mmxh_pkg;

    localparam logic [31:0] GOLD32 = 32'h9E3779B9;
    localparam logic [63:0] GOLD64 = 64'h9E3779B97F4A7C15;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,    // capture input beat, mask tail bytes, compute tail count
        OP_READ,    // registered read of one accumulator
        OP_XML,     // xor data into accumulator, multiply low half
        OP_MH,      // multiply high half
        OP_MXL,     // xorshift mix, multiply low half
        OP_WRITE,   // write mixed word back to accumulator memory
        OP_TAIL,    // fold operand <= tail count
        OP_FXOR,    // fold operand <= premix of (hash ^ accumulator)
        OP_FFIN,    // fold operand <= premix of hash
        OP_P0,      // 64-bit multiply, low x low partial product
        OP_P1,      // high x low cross term
        OP_P2,      // low x high cross term
        OP_P3,      // sum partial products into hash
        OP_OUT      // present digest, return accumulators to reset value
    } t_op;

    typedef struct packed {
        t_op  op;
        logic zero_data;  // absorb zero instead of the captured word
    } t_cmd;

endpackage

// ----- sv/mmxh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmxh_ctrl
// Sequencer for the hash core: walks each beat through the absorb steps,
// pads the block with zero words, then runs the fold over all accumulators.
// ----------------------------------------------------------------------------
module mmxh_ctrl #(
    parameter  int unsigned BLOCK_WORDS = 16,
    localparam int unsigned AW          = $clog2(BLOCK_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_in_last,
    input  logic [3:0]        i_in_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mmxh_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]     o_addr
);
    import mmxh_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(BLOCK_WORDS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_XML  = 4'd2;
    localparam logic [3:0] S_MH1  = 4'd3;
    localparam logic [3:0] S_MXL  = 4'd4;
    localparam logic [3:0] S_MH2  = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_TAIL = 4'd7;
    localparam logic [3:0] S_FRD  = 4'd8;
    localparam logic [3:0] S_FXOR = 4'd9;
    localparam logic [3:0] S_FFIN = 4'd10;
    localparam logic [3:0] S_P0   = 4'd11;
    localparam logic [3:0] S_P1   = 4'd12;
    localparam logic [3:0] S_P2   = 4'd13;
    localparam logic [3:0] S_P3   = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    // what the 64-bit multiply is working on
    localparam logic [1:0] PH_TAIL = 2'd0;
    localparam logic [1:0] PH_ACC  = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_k, n_k;
    logic          r_last, n_last;
    logic          r_full, n_full;
    logic          r_pad, n_pad;
    logic [1:0]    r_phase, n_phase;
    logic          r_out_valid, n_out_valid;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_k         = r_k;
        n_last      = r_last;
        n_full      = r_full;
        n_pad       = r_pad;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '{op: OP_NONE, zero_data: 1'b0};
        o_addr      = r_k;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_addr     = r_pos;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_k      = r_pos;
                    n_last   = i_in_last;
                    n_full   = i_in_last && (i_in_count >= 4'd8) && (r_pos == LAST);
                    n_pad    = 1'b0;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = OP_READ;
                n_state  = S_XML;
            end
            S_XML: begin
                o_cmd.op        = OP_XML;
                o_cmd.zero_data = r_pad;
                n_state         = S_MH1;
            end
            S_MH1: begin
                o_cmd.op = OP_MH;
                n_state  = S_MXL;
            end
            S_MXL: begin
                o_cmd.op = OP_MXL;
                n_state  = S_MH2;
            end
            S_MH2: begin
                o_cmd.op = OP_MH;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.op = OP_WRITE;
                if (!r_last) begin
                    n_pos   = (r_k == LAST) ? '0 : r_k + AW'(1);
                    n_state = S_IDLE;
                end else if (!r_pad && r_full) begin
                    // block was exactly full: absorb one whole zero block
                    n_k     = '0;
                    n_pad   = 1'b1;
                    n_state = S_RD;
                end else if (r_k == LAST) begin
                    n_state = S_TAIL;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_pad   = 1'b1;
                    n_state = S_RD;
                end
            end
            S_TAIL: begin
                o_cmd.op = OP_TAIL;
                n_phase  = PH_TAIL;
                n_k      = '0;
                n_state  = S_P0;
            end
            S_FRD: begin
                o_cmd.op = OP_READ;
                n_state  = S_FXOR;
            end
            S_FXOR: begin
                o_cmd.op = OP_FXOR;
                n_phase  = PH_ACC;
                n_state  = S_P0;
            end
            S_FFIN: begin
                o_cmd.op = OP_FFIN;
                n_phase  = PH_FIN;
                n_state  = S_P0;
            end
            S_P0: begin
                o_cmd.op = OP_P0;
                n_state  = S_P1;
            end
            S_P1: begin
                o_cmd.op = OP_P1;
                n_state  = S_P2;
            end
            S_P2: begin
                o_cmd.op = OP_P2;
                n_state  = S_P3;
            end
            S_P3: begin
                o_cmd.op = OP_P3;
                unique case (r_phase)
                    PH_TAIL: n_state = S_FRD;
                    PH_ACC: begin
                        if (r_k == LAST) begin
                            n_state = S_FFIN;
                        end else begin
                            n_k     = r_k + AW'(1);
                            n_state = S_FRD;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_pos       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_full      <= 1'b0;
            r_pad       <= 1'b0;
            r_phase     <= PH_TAIL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_last      <= n_last;
            r_full      <= n_full;
            r_pad       <= n_pad;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/mmxh_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmxh_datapath
// Accumulator memory with per-entry valid bits, one shared 32x32 multiplier,
// absorb and fold registers, and the digest output register.
// ----------------------------------------------------------------------------
module mmxh_datapath #(
    parameter  int unsigned BLOCK_WORDS = 16,
    localparam int unsigned AW          = $clog2(BLOCK_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmxh_pkg::t_cmd    i_cmd,
    input  logic [AW-1:0]     i_addr,
    input  logic [63:0]       i_data,
    input  logic [3:0]        i_count,
    input  logic              i_last,
    output logic [63:0]       o_hash
);
    import mmxh_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(BLOCK_WORDS - 1);
    localparam int unsigned   TW   = AW + 4;

    // reset value of accumulator k
    function automatic logic [63:0] acc_init(input logic [31:0] k);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = GOLD32 * ((k << 1) + 32'd1);
        hi = GOLD32 * ((k << 1) + 32'd2);
        return {hi, lo};
    endfunction

    logic [63:0]            mem [BLOCK_WORDS];
    logic [BLOCK_WORDS-1:0] r_valid;
    logic [63:0]            r_rd;
    logic                   r_rd_ok;
    logic [63:0]            r_init;
    logic [63:0]            r_data;
    logic [TW-1:0]          r_tail;
    logic [63:0]            r_x;
    logic [63:0]            r_f;
    logic [63:0]            r_p;
    logic [31:0]            r_c;
    logic [63:0]            r_h;
    logic [63:0]            r_out;

    logic [3:0]  cnt;
    logic [63:0] mask;
    logic        full;
    logic [63:0] acc_eff;
    logic [63:0] x_in;
    logic [63:0] mixed;
    logic [63:0] hx;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // input beat conditioning: clamp count, zero unused bytes on the last beat
    always_comb begin
        cnt = (i_count > 4'd8) ? 4'd8 : i_count;
        for (int i = 0; i < 8; i++) begin
            mask[i*8 +: 8] = (!i_last || (4'(i) < cnt)) ? 8'hFF : 8'h00;
        end
        full = (cnt == 4'd8) && (i_addr == LAST);
    end

    // accumulator as stored, or its reset value if not yet written
    assign acc_eff = r_rd_ok ? r_rd : r_init;
    assign x_in    = acc_eff ^ (i_cmd.zero_data ? 64'd0 : r_data);
    assign mixed   = r_x ^ (r_x >> 16) ^ (r_x << 32);
    assign hx      = r_h ^ acc_eff;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_XML: begin
                mul_a = x_in[31:0];
                mul_b = GOLD32;
            end
            OP_MH: begin
                mul_a = r_x[63:32];
                mul_b = GOLD32;
            end
            OP_MXL: begin
                mul_a = mixed[31:0];
                mul_b = GOLD32;
            end
            OP_P0: begin
                mul_a = r_f[31:0];
                mul_b = GOLD64[31:0];
            end
            OP_P1: begin
                mul_a = r_f[63:32];
                mul_b = GOLD64[31:0];
            end
            OP_P2: begin
                mul_a = r_f[31:0];
                mul_b = GOLD64[63:32];
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_data <= i_data & mask;
                r_tail <= full ? '0 : ({1'b0, i_addr, 3'b000} + {{AW{1'b0}}, cnt});
            end
            OP_READ: begin
                r_rd    <= mem[i_addr];
                r_rd_ok <= r_valid[i_addr];
                r_init  <= acc_init({{(32-AW){1'b0}}, i_addr});
            end
            OP_XML:  r_x <= {x_in[63:32], prod[31:0]};
            OP_MH:   r_x <= {prod[31:0], r_x[31:0]};
            OP_MXL:  r_x <= {mixed[63:32], prod[31:0]};
            OP_TAIL: r_f <= {{(64-TW){1'b0}}, r_tail};
            OP_FXOR: r_f <= hx ^ (hx >> 32);
            OP_FFIN: r_f <= r_h ^ (r_h >> 32);
            OP_P0:   r_p <= prod;
            OP_P1:   r_c <= prod[31:0];
            OP_P2:   r_c <= r_c + prod[31:0];
            OP_P3:   r_h <= r_p + {r_c, 32'd0};
            OP_OUT:  r_out <= r_h ^ (r_h >> 32);
            default: ;
        endcase
    end

    // accumulator memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) begin
            mem[i_addr] <= r_x;
        end
    end

    // valid bits: cleared at reset and after each digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.op == OP_OUT) begin
            r_valid <= '0;
        end else if (i_cmd.op == OP_WRITE) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    assign o_hash = r_out;

endmodule

// ----- sv/multilane_multiply_xorshift_hash_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilane_multiply_xorshift_hash_core
// Stream hash over little-endian 64-bit words with 2*VECTOR_LANES accumulators.
// ----------------------------------------------------------------------------
// A message arrives as 8-byte beats; tlast marks the final beat, whose byte
// count, capped at 8, selects how many low bytes are hashed. Each beat takes
// one accumulator read, four passes through a single shared 32x32
// multiplier and a write-back to the single-port accumulator memory before
// the next beat can be taken. After the last beat the core pads the rest of
// the block with zero words (a whole block of 2*VECTOR_LANES words when the
// block ended exactly full), then folds: the tail count, each accumulator
// and the final mix each go through the 64-bit multiply, and the digest
// register is loaded last. The digest waits in an output register, so a
// new message can start while it is still unread. There is no clearing
// pass; accumulators return to their initial values at once.
module multilane_multiply_xorshift_hash_core #(
    parameter int unsigned VECTOR_LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [63:0] hash_value
);
    import mmxh_pkg::*;

`include "multilane_multiply_xorshift_hash_core_assert.svh"

    localparam int unsigned BW = 2 * VECTOR_LANES;
    localparam int unsigned AW = $clog2(BW);

    t_cmd          cmd;
    logic [AW-1:0] addr;

    mmxh_ctrl #(
        .BLOCK_WORDS (BW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_in_last   (i_s_tlast),
        .i_in_count  (i_s_tdata[67:64]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    mmxh_datapath #(
        .BLOCK_WORDS (BW)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .i_data  (i_s_tdata[63:0]),
        .i_count (i_s_tdata[67:64]),
        .i_last  (i_s_tlast),
        .o_hash  (o_m_tdata)
    );

    // busy right after a beat is taken
    `MMXH_ASSERT_NXT(a_busy_after_beat, i_s_tvalid && o_s_tready, !o_s_tready)
    // a digest never overwrites one that is still waiting
    `MMXH_ASSERT_IMP(a_no_overwrite, cmd.op == OP_OUT, !o_m_tvalid || i_m_tready)
    // loading a digest raises output valid
    `MMXH_ASSERT_NXT(a_out_follows, cmd.op == OP_OUT, o_m_tvalid)
    // idle and ready means no datapath work is in flight
    `MMXH_ASSERT_IMP(a_idle_quiet, o_s_tready && !i_s_tvalid, cmd.op == OP_NONE)

endmodule

// ----- tb/mmxh_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmxh_digest_checker
// Watches both stream channels of the hash core. Every input beat taken by
// the core is run through a local model of the lane accumulators; on a tlast
// beat the block padding and the fold are computed and the digest is queued.
// Every digest beat the core delivers is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module mmxh_digest_checker #(
    parameter int unsigned LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic        i_s_tlast,   // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // [63:0] hash_value
    output int          o_fail_count,
    output int          o_pending
);
    import mmxh_pkg::*;

    localparam int unsigned BLOCK_WORDS = 2 * LANES;

    logic [63:0] lane_acc [BLOCK_WORDS];
    int unsigned word_pos;
    logic [63:0] digest_q [$];
    int          fails = 0;

    // each 32-bit half times the 32-bit golden constant, mod 2^32
    function automatic logic [63:0] halves_gold(input logic [63:0] x);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = x[31:0] * GOLD32;
        hi = x[63:32] * GOLD32;
        return {hi, lo};
    endfunction

    // xor a word into one lane, multiply, xorshift, multiply again
    function automatic void mix_lane(input int unsigned k, input logic [63:0] word);
        logic [63:0] y;
        y = halves_gold(lane_acc[k] ^ word);
        y = y ^ (y >> 16) ^ (y << 32);
        lane_acc[k] = halves_gold(y);
    endfunction

    function automatic logic [63:0] fold_gold(input logic [63:0] h);
        return (h ^ (h >> 32)) * GOLD64;
    endfunction

    function automatic void restart_lanes();
        for (int k = 0; k < BLOCK_WORDS; k++) begin
            lane_acc[k] = {GOLD32 * 32'(2 * k + 2), GOLD32 * 32'(2 * k + 1)};
        end
        word_pos = 0;
    endfunction

    // one accepted input beat; a tlast beat pads, folds and queues a digest
    function automatic void take_beat(input logic [63:0] data, input logic [3:0] cnt_in,
                                      input logic is_last);
        int unsigned cnt;
        logic [63:0] word;
        logic [63:0] tail;
        logic [63:0] h;
        word = data;
        if (!is_last) begin
            mix_lane(word_pos, word);
            word_pos = (word_pos + 1 >= BLOCK_WORDS) ? 0 : word_pos + 1;
        end else begin
            // counts above eight act as eight; unused high bytes read as zero
            cnt = (cnt_in > 8) ? 8 : cnt_in;
            if (cnt < 8) word &= (64'd1 << (cnt * 8)) - 64'd1;
            mix_lane(word_pos, word);
            if (cnt == 8 && word_pos == BLOCK_WORDS - 1) begin
                // block ended exactly full: absorb a whole zero block
                for (int k = 0; k < BLOCK_WORDS; k++) mix_lane(k, 64'd0);
                tail = 64'd0;
            end else begin
                for (int k = word_pos + 1; k < BLOCK_WORDS; k++) mix_lane(k, 64'd0);
                tail = 64'(word_pos * 8 + cnt);
            end
            h = tail * GOLD64;
            for (int k = 0; k < BLOCK_WORDS; k++) h = fold_gold(h ^ lane_acc[k]);
            h = fold_gold(h);
            digest_q.push_back(h ^ (h >> 32));
            restart_lanes();
        end
    endfunction

    // sample both channels on every edge
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            restart_lanes();
            digest_q.delete();
        end else begin
            // output side first: a digest can never leave on its own input edge
            if (i_m_tvalid && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: digest beat with none expected, expected none, actual %h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want = digest_q.pop_front();
                    if (want !== i_m_tdata) begin
                        $display("%0t: hash_value mismatch, expected %h, actual %h",
                                 $time, want, i_m_tdata);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_beat(i_s_tdata[63:0], i_s_tdata[67:64], i_s_tlast);
            end
        end
        o_fail_count <= fails;
        o_pending    <= digest_q.size();
    end

endmodule

// ----- tb/multilane_multiply_xorshift_hash_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilane_multiply_xorshift_hash_core_test
// Drives messages into the hash core: a few directed messages (empty message,
// single words with byte counts 0, 7, 8 and above 8, an exactly full block),
// then random messages of mixed length with random gaps on the input and
// random back-pressure on the digest output. The checker beside the core
// predicts and compares every digest; this module gives the verdict.
// ----------------------------------------------------------------------------
module multilane_multiply_xorshift_hash_core_test;

    localparam int unsigned LANES     = 8;
    localparam int          BEAT_GOAL = 1250;
    localparam int          LIMIT     = 2000000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [71:0] i_s_tdata  = '0;    // [63:0] data_word, [67:64] byte_count, rest zero
    logic        i_s_tlast  = 1'b0;  // last
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;          // [63:0] hash_value

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int cycle_count = 0;
    bit hold_req    = 1'b0;

    multilane_multiply_xorshift_hash_core #(
        .VECTOR_LANES(LANES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    mmxh_digest_checker #(
        .LANES(LANES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("multilane_multiply_xorshift_hash_core_test: errors");
            $finish;
        end
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // one input beat; valid stays high into the next beat when no gap follows
    task automatic send_beat(input logic [63:0] data, input logic [3:0] cnt,
                             input logic is_last);
        int gap;
        gap = pick_gap();
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, cnt, data};
        i_s_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        beats_sent++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // body words carry random (ignored) byte counts
    task automatic send_message(input int body, input logic [3:0] last_cnt);
        for (int i = 0; i < body; i++) begin
            send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        end
        send_beat(rand_word(), last_cnt, 1'b1);
    endtask

    // stop offering and wait for every outstanding digest
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // digest sink: random ready pattern, one long hold-off on request
    initial begin : sink
        int  r;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (4000) @(posedge i_clk);
            end else if (r < 55) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end else if (r < 92) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(20, 90)) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : source
        int  r;
        int  body;
        bit  paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message: zero bytes at position zero
        send_beat('1, 4'd0, 1'b1);
        // single words: full, count above eight, partial
        send_beat('1, 4'd8, 1'b1);
        send_beat('1, 4'd15, 1'b1);
        send_beat('1, 4'd7, 1'b1);
        // exactly full block, then a zero word plus a three-byte tail
        send_message(2 * LANES - 1, 4'd8);
        send_beat(64'd0, 4'd0, 1'b0);
        send_beat('1, 4'd3, 1'b1);
        wait_drained();

        // random messages; the sink holds off once early on
        hold_req <= 1'b1;
        while (beats_sent < BEAT_GOAL) begin
            if (!paused && beats_sent >= BEAT_GOAL / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_message(2 * LANES - 1, 4'($urandom_range(8, 15)));
            end else if (r < 15) begin
                send_message(4 * LANES - 1, 4'd8);
            end else begin
                if (r < 20) body = $urandom_range(32, 60);
                else if (r < 28) body = $urandom_range(0, 1);
                else body = $urandom_range(0, 20);
                send_message(body, 4'($urandom_range(0, 15)));
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("multilane_multiply_xorshift_hash_core_test: clean");
        end else begin
            $display("multilane_multiply_xorshift_hash_core_test: errors");
        end
        $finish;
    end

endmodule
